FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion helper macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/lsmn_pkg.sv
// ---------------------------------------------------------------------------
// lsmn_pkg
// types and constants for the line scan median normalizer
// ---------------------------------------------------------------------------
package lsmn_pkg;

   localparam int unsigned LineLengthDef = 128;
   localparam int unsigned SampleBitsDef = 12;
   localparam int unsigned IdxBits       = 7;
   localparam int unsigned LevelBits     = 7;
   localparam int unsigned CfgIdxBits    = 3;
   localparam int unsigned CfgDataBits   = 12;
   localparam logic [6:0]  LevelMax      = 7'd127;

   // register indexes
   localparam logic [2:0] CSR_BLACK  = 3'd0;
   localparam logic [2:0] CSR_WHITE  = 3'd1;
   localparam logic [2:0] CSR_THRESH = 3'd2;
   localparam logic [2:0] CSR_COUNT  = 3'd3;
   localparam logic [2:0] CSR_PASSES = 3'd4;

   // request kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [6:0]  pixel_index;
      logic [11:0] raw_sample;
   } req_type;

   typedef struct packed {
      logic [11:0] filtered_sample;
      logic [6:0]  level;
      logic        active;
   } rsp_type;

   // divider control/status
   typedef struct packed {
      logic        start;
      logic [18:0] dividend;
      logic [11:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      logic [6:0] quotient;
   } div_sts_type;

endpackage

FILE: sv/line_scan_median_normalizer.sv
// a load is taken only while idle; a load of the last pixel also runs the median
//   passes: per pixel a read and a wait state per window tap, 5 sort steps, 1 write
// a read runs the memory read, normalize and output states, with the 7-step divider
//   in between when needed, then waits for any earlier beat held on the response channel
// reset clears control and registers to their defaults; the line is undefined
// ---------------------------------------------------------------------------
// line_scan_median_normalizer
// line store with in-place 5-tap median passes and level normalization
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module line_scan_median_normalizer #(
   parameter int unsigned LINE_LENGTH = lsmn_pkg::LineLengthDef,
   parameter int unsigned SAMPLE_BITS = lsmn_pkg::SampleBitsDef
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lsmn_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lsmn_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lsmn_pkg::CfgIdxBits-1:0]   csr_index,
   input  logic [lsmn_pkg::CfgDataBits-1:0]  csr_data
);
   import lsmn_pkg::*;

   localparam int unsigned AddrBits = $clog2(LINE_LENGTH);
   localparam int unsigned Lim      = (LINE_LENGTH < 128) ? LINE_LENGTH : 128;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_GATH  = 9'b000000010,
      ST_WAITG = 9'b000000100,
      ST_SORT  = 9'b000001000,
      ST_WRITE = 9'b000010000,
      ST_RDMEM = 9'b000100000,
      ST_NORM  = 9'b001000000,
      ST_DIV   = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // registers
   logic [11:0] black_ff, white_ff;
   logic [6:0]  thresh_ff;
   logic [7:0]  count_ff;
   logic [2:0]  passes_ff;

   // line memory
   logic [SAMPLE_BITS-1:0] mem [LINE_LENGTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [AddrBits-1:0]    rd_addr;
   logic                   wr_en;
   logic [AddrBits-1:0]    wr_addr;
   logic [SAMPLE_BITS-1:0] wr_data;

   // sequencer state
   logic [7:0]  pos_ff, pos_in;      // pixel being filtered
   logic [2:0]  tap_ff, tap_in;      // window gather counter
   logic [2:0]  pass_ff, pass_in;
   logic [2:0]  wlen_ff, wlen_in;    // window length
   logic [SAMPLE_BITS-1:0] win_ff [5];
   logic [SAMPLE_BITS-1:0] win_in [5];
   logic [2:0]  srt_ff, srt_in;      // odd-even sort step
   logic [6:0]  ridx_ff, ridx_in;
   logic        oor_ff, oor_in;
   logic [11:0] samp_ff, samp_in;
   rsp_type     res_ff, res_in;      // result waiting for the output register
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [7:0]  npix, npass_m1;
   logic [7:0]  lo;
   logic [7:0]  hi;
   logic [7:0]  gaddr;
   div_cmd_type dcmd;
   div_sts_type dsts;

   // effective pixel count and passes
   always_comb begin
      npix = count_ff;
      if (npix < 8'd5) npix = 8'd5;
      if (npix > 8'(Lim)) npix = 8'(Lim);
      npass_m1 = 8'(passes_ff) - 8'd1;
      if (passes_ff == 3'd0) npass_m1 = 8'd0;
      if (passes_ff > 3'd4) npass_m1 = 8'd3;
   end

   // window bounds of current pixel
   always_comb begin
      lo = (pos_ff >= 8'd2) ? pos_ff - 8'd2 : 8'd0;
      hi = (pos_ff + 8'd2 <= npix - 8'd1) ? pos_ff + 8'd2 : npix - 8'd1;
      gaddr = lo + 8'(tap_ff);
   end

   // configuration is always taken
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         black_ff  <= 12'd0;
         white_ff  <= 12'd4095;
         thresh_ff <= 7'd80;
         count_ff  <= 8'd100;
         passes_ff <= 3'd2;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BLACK:  black_ff  <= csr_data;
            CSR_WHITE:  white_ff  <= csr_data;
            CSR_THRESH: thresh_ff <= csr_data[6:0];
            CSR_COUNT:  count_ff  <= csr_data[7:0];
            CSR_PASSES: passes_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      tap_in       = tap_ff;
      pass_in      = pass_ff;
      wlen_in      = wlen_ff;
      win_in       = win_ff;
      srt_in       = srt_ff;
      ridx_in      = ridx_ff;
      oor_in       = oor_ff;
      samp_in      = samp_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = AddrBits'(req_payload.pixel_index);
      wr_data      = SAMPLE_BITS'(req_payload.raw_sample);
      rd_addr      = AddrBits'(gaddr);
      dcmd         = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.kind == KIND_LOAD) begin
                  if (8'(req_payload.pixel_index) < npix) begin
                     wr_en = 1'b1;
                     if (8'(req_payload.pixel_index) == npix - 8'd1) begin
                        pos_in   = '0;
                        tap_in   = '0;
                        pass_in  = '0;
                        state_in = ST_GATH;
                     end
                  end
               end else begin
                  ridx_in  = req_payload.pixel_index;
                  oor_in   = 8'(req_payload.pixel_index) >= npix;
                  state_in = ST_RDMEM;
               end
            end
         end
         ST_GATH: begin
            // issue window read
            wlen_in  = 3'(hi - lo + 8'd1);
            state_in = ST_WAITG;
         end
         ST_WAITG: begin
            win_in[tap_ff] = rd_data_ff;
            if (gaddr == hi) begin
               srt_in   = '0;
               state_in = ST_SORT;
            end else begin
               tap_in   = tap_ff + 3'd1;
               state_in = ST_GATH;
            end
         end
         ST_SORT: begin
            // odd-even transposition step over valid taps
            for (int i = 0; i < 4; i++) begin
               if ((i % 2) == int'(srt_ff[0]) && 3'(i + 1) < wlen_ff &&
                   win_ff[i] > win_ff[i+1]) begin
                  win_in[i]   = win_ff[i+1];
                  win_in[i+1] = win_ff[i];
               end
            end
            srt_in = srt_ff + 3'd1;
            if (srt_ff == 3'd4) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = AddrBits'(pos_ff);
            wr_data = win_ff[wlen_ff >> 1];
            tap_in  = '0;
            if (pos_ff == npix - 8'd1) begin
               pos_in = '0;
               if (8'(pass_ff) == npass_m1) state_in = ST_IDLE;
               else begin
                  pass_in  = pass_ff + 3'd1;
                  state_in = ST_GATH;
               end
            end else begin
               pos_in   = pos_ff + 8'd1;
               state_in = ST_GATH;
            end
         end
         ST_RDMEM: begin
            rd_addr  = AddrBits'(ridx_ff);
            state_in = ST_NORM;
         end
         ST_NORM: begin
            samp_in = oor_ff ? 12'd0 : 12'(rd_data_ff);
            if (oor_ff) begin
               res_in   = '0;
               state_in = ST_OUT;
            end else if (12'(rd_data_ff) >= white_ff) begin
               res_in.filtered_sample = 12'(rd_data_ff);
               res_in.level  = LevelMax;
               res_in.active = LevelMax < thresh_ff;
               state_in = ST_OUT;
            end else if (12'(rd_data_ff) <= black_ff) begin
               res_in.filtered_sample = 12'(rd_data_ff);
               res_in.level  = '0;
               res_in.active = 7'd0 < thresh_ff;
               state_in = ST_OUT;
            end else begin
               dcmd.start    = 1'b1;
               dcmd.dividend = 19'({7'd0, 12'(rd_data_ff) - black_ff} * 19'd127);
               dcmd.divisor  = white_ff - black_ff;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (dsts.done) begin
               res_in.filtered_sample = samp_ff;
               res_in.level  = dsts.quotient;
               res_in.active = dsts.quotient < thresh_ff;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // load the output register once the previous beat has left
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // line memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         tap_ff       <= '0;
         pass_ff      <= '0;
         srt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         tap_ff       <= tap_in;
         pass_ff      <= pass_in;
         srt_ff       <= srt_in;
      end
      wlen_ff <= wlen_in;
      win_ff  <= win_in;
      ridx_ff <= ridx_in;
      oor_ff  <= oor_in;
      samp_ff <= samp_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   lsmn_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (dcmd),
      .sts   (dsts)
   );

   // checks
   `ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_IMPL(a_div_only_div, clock, reset, dsts.busy,
                state_ff == ST_DIV)

endmodule

FILE: sv/lsmn_div.sv
// ---------------------------------------------------------------------------
// lsmn_div
// restoring divider, one quotient bit per cycle, 7-bit quotient
// ---------------------------------------------------------------------------
module lsmn_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lsmn_pkg::div_cmd_type cmd,
   output lsmn_pkg::div_sts_type sts
);
   import lsmn_pkg::*;

   logic [18:0] rem_ff, rem_in;
   logic [11:0] dvs_ff, dvs_in;
   logic [6:0]  quo_ff, quo_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [18:0] shifted;
   logic [2:0]  bit_pos;

   // one subtract-and-compare per cycle
   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_pos = 3'd6 - cnt_ff;
      shifted = {7'd0, dvs_ff} << bit_pos;
      if (cmd.start) begin
         rem_in  = cmd.dividend;
         dvs_in  = cmd.divisor;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= shifted) begin
            rem_in = rem_ff - shifted;
            quo_in = quo_ff | (7'd1 << bit_pos);
         end
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd6) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule

FILE: dv/lsmn_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lsmn_checker
// Watches the request, response and register channels of the line scan
// median normalizer. It keeps its own copy of the line and the registers,
// works out each read response when the read is accepted, and compares the
// response beats in order.
// ---------------------------------------------------------------------------
module lsmn_checker
   import lsmn_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  req_type                 req_payload,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rsp_type                 rsp_payload,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CfgIdxBits-1:0]   csr_index,
   input  logic [CfgDataBits-1:0]  csr_data,
   output int                      fail_count,
   output int                      pending
);

   logic [11:0] line_mem [128];
   logic [11:0] black_lvl;
   logic [11:0] white_lvl;
   logic [6:0]  thresh;
   logic [7:0]  pix_count;
   logic [2:0]  pass_count;
   rsp_type     read_results_q[$];

   function automatic int eff_pixels();
      int n;
      n = pix_count;
      if (n < 5) n = 5;
      if (n > 128) n = 128;
      return n;
   endfunction

   function automatic int eff_passes();
      int p;
      p = pass_count;
      if (p < 1) p = 1;
      if (p > 4) p = 4;
      return p;
   endfunction

   function automatic logic [6:0] norm_level(logic [11:0] s);
      int num;
      if (s >= white_lvl) return LevelMax;
      if (s <= black_lvl) return 7'd0;
      num = (int'(s) - int'(black_lvl)) * 127;
      return 7'(num / (int'(white_lvl) - int'(black_lvl)));
   endfunction

   // in-place passes, earlier pixels already hold this pass's values
   task automatic apply_median_passes(int n);
      int lo, hi, k, m;
      logic [11:0] win [5];
      logic [11:0] v;
      for (int p = 0; p < eff_passes(); p++) begin
         for (int i = 0; i < n; i++) begin
            lo = (i >= 2) ? i - 2 : 0;
            hi = (i + 2 <= n - 1) ? i + 2 : n - 1;
            k = hi - lo + 1;
            for (int j = 0; j < k; j++) begin
               v = line_mem[lo + j];
               m = j;
               while (m > 0 && win[m - 1] > v) begin
                  win[m] = win[m - 1];
                  m--;
               end
               win[m] = v;
            end
            line_mem[i] = win[k / 2];
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_rsp;
      rsp_type got;
      int n;
      if (reset) begin
         black_lvl  = 12'd0;
         white_lvl  = 12'd4095;
         thresh     = 7'd80;
         pix_count  = 8'd100;
         pass_count = 3'd2;
         read_results_q.delete();
         fail_count = 0;
      end else begin
         // response beat against oldest expectation
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (read_results_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t unexpected response beat %p", $realtime, got);
            end else begin
               exp_rsp = read_results_q.pop_front();
               if (got.filtered_sample !== exp_rsp.filtered_sample ||
                   got.level !== exp_rsp.level || got.active !== exp_rsp.active) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t mismatch: sample exp %0d got %0d, ",
                               "level exp %0d got %0d, active exp %0d got %0d"},
                              $realtime, exp_rsp.filtered_sample, got.filtered_sample,
                              exp_rsp.level, got.level, exp_rsp.active, got.active);
               end
            end
         end
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BLACK:  black_lvl  = csr_data;
               CSR_WHITE:  white_lvl  = csr_data;
               CSR_THRESH: thresh     = csr_data[6:0];
               CSR_COUNT:  pix_count  = csr_data[7:0];
               CSR_PASSES: pass_count = csr_data[2:0];
               default: ;
            endcase
         end
         // request beat: load updates the line, read queues a response
         if (req_valid && req_ready) begin
            n = eff_pixels();
            if (req_payload.kind == KIND_LOAD) begin
               if (req_payload.pixel_index < n) begin
                  line_mem[req_payload.pixel_index] = req_payload.raw_sample;
                  if (req_payload.pixel_index == n - 1) apply_median_passes(n);
               end
            end else begin
               if (req_payload.pixel_index >= n) begin
                  exp_rsp = '0;
               end else begin
                  exp_rsp.filtered_sample = line_mem[req_payload.pixel_index];
                  exp_rsp.level = norm_level(exp_rsp.filtered_sample);
                  exp_rsp.active = (exp_rsp.level < thresh);
               end
               read_results_q.push_back(exp_rsp);
            end
         end
      end
      pending = read_results_q.size();
   end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the line scan median normalizer. Each phase sets
// the registers while the block is idle, loads a full line in order, then
// mixes random reads and loads; the checker predicts and compares.
// ---------------------------------------------------------------------------
module tb;
   import lsmn_pkg::*;

   localparam int CycleLimit = 10000000;
   localparam int PassDrain  = 9000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CfgIdxBits-1:0]  csr_index = '0;
   logic [CfgDataBits-1:0] csr_data = '0;
   int                     fail_count;
   int                     pending;
   int                     gap_pct = 0;
   int                     stall_pct = 0;
   int                     cycles = 0;
   int                     line_len = 100;

   always #6 clock = ~clock;

   line_scan_median_normalizer i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   lsmn_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending
   );

   // receiver stalls
   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // one request beat, entered and left at a falling edge
   task automatic send_beat(logic kind, logic [6:0] idx, logic [11:0] sample);
      req_type r;
      r.kind = kind;
      r.pixel_index = idx;
      r.raw_sample = sample;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [11:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [11:0] pick_sample();
      case ($urandom_range(7))
         0: return 12'd0;
         1: return 12'd4095;
         default: return 12'($urandom_range(4095));
      endcase
   endfunction

   // block idle: responses drained, then room for a full median run
   task automatic wait_idle();
      while (pending != 0) @(negedge clock);
      repeat (PassDrain) @(negedge clock);
   endtask

   initial begin
      logic [11:0] bl, wh, th, cnt, ps;
      int counted, idx, n;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: shortest line, single pass, edge values
      write_reg(CSR_COUNT, 12'd0);
      write_reg(CSR_PASSES, 12'd0);
      line_len = 5;
      send_beat(KIND_LOAD, 7'd0, 12'd0);
      send_beat(KIND_LOAD, 7'd1, 12'd4095);
      send_beat(KIND_LOAD, 7'd2, 12'd4095);
      send_beat(KIND_LOAD, 7'd3, 12'd0);
      send_beat(KIND_LOAD, 7'd4, 12'd2048);
      for (int i = 0; i < 5; i++) send_beat(KIND_READ, 7'(i), 12'd0);
      send_beat(KIND_READ, 7'd127, 12'hfff);
      send_beat(KIND_READ, 7'd5, 12'd0);
      send_beat(KIND_LOAD, 7'd127, 12'd1234);
      send_beat(KIND_LOAD, 7'd2, 12'd17);
      send_beat(KIND_LOAD, 7'd4, 12'd4000);
      send_beat(KIND_READ, 7'd0, 12'd0);
      send_beat(KIND_READ, 7'd4, 12'd0);
      req_valid <= 1'b0;
      wait_idle();

      for (int phase = 1; phase <= 11; phase++) begin
         case (phase % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 46; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 46; end
            default: begin gap_pct = 30; stall_pct = 30; end
         endcase
         // register settings, extremes first
         case (phase)
            1: begin bl = 0;    wh = 4095; th = 0;   cnt = 255; ps = 7; end
            2: begin bl = 4095; wh = 0;    th = 127; cnt = 128; ps = 4; end
            3: begin bl = 2048; wh = 2048; th = 64;  cnt = 5;   ps = 1; end
            4: begin bl = 100;  wh = 3900; th = 127; cnt = 4;   ps = 0; end
            default: begin
               bl = 12'($urandom_range(2047));
               wh = 12'($urandom_range(4095, 2048));
               th = 12'($urandom_range(4095));
               cnt = 12'($urandom_range(4095));
               ps = 12'($urandom_range(4095));
            end
         endcase
         write_reg(CSR_BLACK, bl);
         write_reg(CSR_WHITE, wh);
         write_reg(CSR_THRESH, th);
         write_reg(CSR_COUNT, cnt);
         write_reg(CSR_PASSES, ps);
         n = cnt[7:0];
         if (n < 5) n = 5;
         if (n > 128) n = 128;
         line_len = n;

         // full line in order so no window ever sees an unwritten pixel
         for (int i = 0; i < line_len; i++) send_beat(KIND_LOAD, 7'(i), pick_sample());

         counted = 0;
         while (counted < 90) begin
            if ($urandom_range(99) < 55) begin
               idx = ($urandom_range(99) < 85) ? $urandom_range(line_len - 1)
                                               : $urandom_range(127);
               send_beat(KIND_READ, 7'(idx), 12'($urandom_range(4095)));
               counted++;
            end else begin
               idx = ($urandom_range(9) == 0) ? line_len - 1 : $urandom_range(127);
               send_beat(KIND_LOAD, 7'(idx), pick_sample());
               if (idx < line_len) counted++;
            end
         end
         req_valid <= 1'b0;
         wait_idle();
      end

      gap_pct = 0;
      stall_pct = 0;
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
